// File: hdl/u8u16_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
// No dependencies; imported by every module of the block.
package u8u16_pkg;

  localparam logic [15:0] REPL_UNIT   = 16'hfffd;
  localparam logic [15:0] HI_SURR     = 16'hd800;
  localparam logic [15:0] LO_SURR     = 16'hdc00;
  localparam logic [20:0] SUPP_BASE   = 21'h010000;
  localparam logic [7:0]  LEAD_MIN    = 8'hc2;
  localparam logic [7:0]  LEAD_LIMIT  = 8'hf5;
  localparam logic [7:0]  LEAD_E0     = 8'he0;
  localparam logic [7:0]  LEAD_ED     = 8'hed;
  localparam logic [7:0]  LEAD_F0     = 8'hf0;
  localparam logic [7:0]  LEAD_F4     = 8'hf4;
  localparam logic [7:0]  CONT_A0     = 8'ha0;
  localparam logic [7:0]  CONT_90     = 8'h90;
  localparam int          MAX_UNITS   = 4;

  // Units produced by one byte, handed from the decoder to the emitter.
  typedef struct packed {
    logic                  valid;
    logic [2:0]            cnt;
    logic                  last;
    logic [3:0][15:0]      codes;
  } burst_t;

endpackage

// File: hdl/u8u16_decode.sv
// UTF-8 sequence decoder: keeps the pending-sequence state and turns each
// accepted byte into a burst of zero to four UTF-16 units. Uses u8u16_pkg.
module u8u16_decode import u8u16_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_string_last,
  input  logic        load_ok,
  output burst_t      burst
);

  typedef struct packed {
    logic        emit;
    logic [15:0] unit;
    logic [2:0]  len;
    logic [20:0] partial;
  } lead_t;

  logic [20:0] part_r, part_nxt;
  logic [7:0]  lead_r, lead_nxt;
  logic [2:0]  len_r, len_nxt;
  logic [2:0]  taken_r, taken_nxt;

  logic        accept;
  lead_t       ld;
  logic        ok;
  logic        use_lead;
  logic [20:0] part_shift;
  logic [2:0]  taken_p1;
  logic [19:0] supp;
  logic [1:0]  k;
  logic [1:0]  tcnt;
  logic [15:0] t0, t1;

  function automatic lead_t lead_decode(input logic [7:0] b);
    lead_t r;
    r = '0;
    if (!b[7]) begin
      r.emit = 1'b1;
      r.unit = {8'h00, b};
    end else if (b < LEAD_MIN || b >= LEAD_LIMIT) begin
      r.emit = 1'b1;
      r.unit = REPL_UNIT;
    end else if (b < LEAD_E0) begin
      r.len     = 3'd2;
      r.partial = {16'h0000, b[4:0]};
    end else if (b < LEAD_F0) begin
      r.len     = 3'd3;
      r.partial = {17'h00000, b[3:0]};
    end else begin
      r.len     = 3'd4;
      r.partial = {18'h00000, b[2:0]};
    end
    return r;
  endfunction

  assign accept   = in_valid && load_ok;
  assign in_stall = !load_ok;

  assign ld         = lead_decode(in_byte);
  assign part_shift = {part_r[14:0], in_byte[5:0]};
  assign taken_p1   = taken_r + 3'd1;
  assign supp       = part_shift[19:0] - SUPP_BASE[19:0];

  always_comb begin
    ok = (in_byte[7:6] == 2'b10);
    if (taken_r == 3'd1) begin
      if (lead_r == LEAD_E0 && in_byte <  CONT_A0) ok = 1'b0;
      if (lead_r == LEAD_ED && in_byte >= CONT_A0) ok = 1'b0;
      if (lead_r == LEAD_F0 && in_byte <  CONT_90) ok = 1'b0;
      if (lead_r == LEAD_F4 && in_byte >= CONT_90) ok = 1'b0;
    end
  end

  always_comb begin
    part_nxt  = part_r;
    lead_nxt  = lead_r;
    len_nxt   = len_r;
    taken_nxt = taken_r;
    use_lead  = 1'b0;
    k         = 2'd0;
    tcnt      = 2'd0;
    t0        = REPL_UNIT;
    t1        = REPL_UNIT;
    if (len_r == 3'd0) begin
      use_lead = 1'b1;
    end else if (ok) begin
      part_nxt  = part_shift;
      taken_nxt = taken_p1;
      if (taken_p1 >= len_r) begin
        if (part_shift[20:16] != 5'd0) begin
          tcnt = 2'd2;
          t0   = HI_SURR | {6'd0, supp[19:10]};
          t1   = LO_SURR | {6'd0, supp[9:0]};
        end else begin
          tcnt = 2'd1;
          t0   = part_shift[15:0];
        end
        part_nxt  = '0;
        lead_nxt  = '0;
        len_nxt   = '0;
        taken_nxt = '0;
      end else if (in_string_last) begin
        // flush: one replacement per byte taken, this one included
        k = taken_p1[1:0];
      end
    end else begin
      // bad follower: replace lead and taken continuations, rescan this byte
      k         = taken_r[1:0];
      part_nxt  = '0;
      lead_nxt  = '0;
      len_nxt   = '0;
      taken_nxt = '0;
      use_lead  = 1'b1;
    end

    if (use_lead) begin
      if (ld.emit) begin
        tcnt = 2'd1;
        t0   = ld.unit;
      end else begin
        lead_nxt  = in_byte;
        taken_nxt = 3'd1;
        len_nxt   = ld.len;
        part_nxt  = ld.partial;
        if (in_string_last) begin
          tcnt = 2'd1;
          t0   = REPL_UNIT;
        end
      end
    end

    if (in_string_last) begin
      part_nxt  = '0;
      lead_nxt  = '0;
      len_nxt   = '0;
      taken_nxt = '0;
    end
  end

  always_comb begin
    burst.cnt   = {1'b0, k} + {1'b0, tcnt};
    burst.valid = accept && (burst.cnt != 3'd0);
    burst.last  = in_string_last;
    for (int i = 0; i < MAX_UNITS; i++) begin
      if (i < int'(k)) begin
        burst.codes[i] = REPL_UNIT;
      end else if (i == int'(k)) begin
        burst.codes[i] = t0;
      end else begin
        burst.codes[i] = t1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      part_r  <= '0;
      lead_r  <= '0;
      len_r   <= '0;
      taken_r <= '0;
    end else if (accept) begin
      part_r  <= part_nxt;
      lead_r  <= lead_nxt;
      len_r   <= len_nxt;
      taken_r <= taken_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (len_r == 3'd0) |-> (taken_r == 3'd0))
    else $error("idle decoder holds taken bytes");
  a_pending_range: assert property (@(posedge clk) disable iff (!rst_n)
    (len_r != 3'd0) |-> (taken_r != 3'd0 && taken_r < len_r && len_r >= 3'd2))
    else $error("pending sequence count out of range");
  a_last_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_string_last) |=> (len_r == 3'd0))
    else $error("sequence still pending after end of string");
  a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_string_last) |-> burst.valid)
    else $error("final byte produced no unit");
`endif

endmodule

// File: hdl/u8u16_emit.sv
// Unit emitter: holds one burst, sends its units one per cycle unless stalled,
// via the output register with index, capacity flag, end flags. Uses u8u16_pkg.
module u8u16_emit import u8u16_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  burst_t      burst,
  output logic        load_ok,
  input  logic [31:0] capacity,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_code_unit,
  output logic [31:0] out_unit_index,
  output logic        out_fits_capacity,
  output logic        out_run_end,
  output logic        out_string_end
);

  logic [3:0][15:0] codes_r;
  logic [2:0]       cnt_r;
  logic [1:0]       ptr_r;
  logic             last_r;
  logic             busy_r;
  logic [31:0]      units_r, units_nxt;

  logic             out_valid_r;
  logic [15:0]      code_r;
  logic [31:0]      index_r;
  logic             fits_r;
  logic             run_end_r;
  logic             str_end_r;

  logic             send;
  logic             run_end;
  logic             str_end;
  logic             done;

  assign send    = busy_r && (!out_valid_r || !out_stall);
  assign run_end = ({1'b0, ptr_r} + 3'd1) == cnt_r;
  assign str_end = run_end && last_r;
  assign done    = send && run_end;
  assign load_ok = !busy_r || done;

  // index restarts for the next string after its final unit
  assign units_nxt = str_end ? 32'd0 : units_r + 32'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      ptr_r   <= '0;
      units_r <= '0;
    end else begin
      if (burst.valid) begin
        busy_r <= 1'b1;
        ptr_r  <= '0;
      end else if (done) begin
        busy_r <= 1'b0;
      end else if (send) begin
        ptr_r <= ptr_r + 2'd1;
      end
      if (send) begin
        units_r <= units_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (burst.valid) begin
      codes_r <= burst.codes;
      cnt_r   <= burst.cnt;
      last_r  <= burst.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (send) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (send) begin
      code_r    <= codes_r[ptr_r];
      index_r   <= units_r;
      fits_r    <= units_r < capacity;
      run_end_r <= run_end;
      str_end_r <= str_end;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_code_unit     = code_r;
  assign out_unit_index    = index_r;
  assign out_fits_capacity = fits_r;
  assign out_run_end       = run_end_r;
  assign out_string_end    = str_end_r;

`ifndef NO_ASSERTIONS
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> ({1'b0, ptr_r} < cnt_r && cnt_r != 3'd0))
    else $error("unit pointer beyond burst");
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    burst.valid |-> load_ok)
    else $error("burst loaded over a busy one");
  a_index_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (send && str_end) |=> (units_r == 32'd0))
    else $error("unit index not restarted after end of string");
  a_run_end_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_string_end) |-> out_run_end)
    else $error("string end without run end");
`endif

endmodule

// File: hdl/utf8_to_utf16_transcoder_top.sv
// Top level of the UTF-8 to UTF-16 transcoder: capacity register, decoder
// and unit emitter. Depends on u8u16_pkg, u8u16_decode and u8u16_emit.
//
// Takes one UTF-8 byte per request and returns UTF-16 code units, one per
// cycle unless the output stalls, each with its index in the output string
// and a flag telling whether that index is below the configured capacity.
// Unless the output stalls, a byte that yields a single unit is taken every
// cycle; one that yields more (surrogate pair or run of U+FFFD replacements,
// at most four) holds the input until its last unit is sent, as the emitter
// sends one unit per cycle through its output register. Bytes that only
// extend a pending sequence produce no unit. Write the capacity register
// only while no units are outstanding.
module utf8_to_utf16_transcoder_top import u8u16_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_string_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_code_unit,
  output logic [31:0] out_unit_index,
  output logic        out_fits_capacity,
  output logic        out_run_end,
  output logic        out_string_end
);

  logic [31:0] capacity_r;
  burst_t      burst;
  logic        load_ok;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= 32'hffff_ffff;
    end else if (cfg_valid && cfg_ready) begin
      capacity_r <= cfg_data;
    end
  end

  u8u16_decode u_decode (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .in_string_last (in_string_last),
    .load_ok        (load_ok),
    .burst          (burst)
  );

  u8u16_emit u_emit (
    .clk               (clk),
    .rst_n             (rst_n),
    .burst             (burst),
    .load_ok           (load_ok),
    .capacity          (capacity_r),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_code_unit     (out_code_unit),
    .out_unit_index    (out_unit_index),
    .out_fits_capacity (out_fits_capacity),
    .out_run_end       (out_run_end),
    .out_string_end    (out_string_end)
  );

endmodule
